// File: sv/arinc429_label_statistics_macros.svh
// ----------------------------------------------------------------------------
// ARINC 429 label statistics: assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARINC429_LABEL_STATISTICS_MACROS_SVH
`define ARINC429_LABEL_STATISTICS_MACROS_SVH

// Same-cycle implication: when cond holds, prop holds at the same edge.
`define ALS_ASSERT_SAME(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("ALS assertion failed");

// Next-cycle implication: when cond holds, prop holds at the following edge.
`define ALS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("ALS assertion failed");

`endif

// File: sv/als_pkg.sv
// ----------------------------------------------------------------------------
// ARINC 429 label statistics: shared package
// Widths, codes and record types used by the monitor modules.
// ----------------------------------------------------------------------------
package als_pkg;

  // Table depth default and counter width.
  localparam int unsigned LabelEntriesDef = 256;
  localparam int unsigned CntW            = 32;

  // Input command codes.
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Channels with their own counters.
  localparam logic [1:0] CHAN_ONE = 2'd1;
  localparam logic [1:0] CHAN_TWO = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_LABEL_FILTER_ON   = 2'd0;
  localparam logic [1:0] REG_MATCH_LABEL       = 2'd1;
  localparam logic [1:0] REG_CHANNEL_FILTER_ON = 2'd2;
  localparam logic [1:0] REG_MATCH_CHANNEL     = 2'd3;

  // Reset value of the channel match register.
  localparam logic [1:0] MATCH_CHANNEL_RST = 2'd1;

  // Filter settings.
  typedef struct packed {
    logic       label_filter_on;
    logic [7:0] match_label;
    logic       channel_filter_on;
    logic [1:0] match_channel;
  } cfg_t;

  // Verdicts for one word.
  typedef struct packed {
    logic good;
    logic match;
  } chk_t;

  // One table entry: the four per-label counters.
  typedef struct packed {
    logic [CntW-1:0] words;
    logic [CntW-1:0] ch1;
    logic [CntW-1:0] ch2;
    logic [CntW-1:0] errs;
  } cnt_t;

endpackage

// File: sv/als_word_chk.sv
// ----------------------------------------------------------------------------
// ARINC 429 label statistics: word checker
// Rebuilds word bits 0..30, checks odd parity and applies the filters.
// ----------------------------------------------------------------------------
module als_word_chk
  import als_pkg::*;
(
  input  cfg_t        cfg_i,
  input  logic [1:0]  chan_i,
  input  logic [7:0]  label_i,
  input  logic [1:0]  sdi_i,
  input  logic [18:0] payload_i,
  input  logic [1:0]  ssm_i,
  input  logic        parity_in_i,
  output chk_t        chk_o
);

  logic [30:0] word;

  // Word bits 0..30 as sent on the bus.
  assign word = {ssm_i, payload_i, sdi_i, label_i};

  // The whole 32-bit word must hold an odd number of ones.
  assign chk_o.good = ^{parity_in_i, word};

  // A word matches when it passes every enabled filter.
  assign chk_o.match = !(cfg_i.label_filter_on && (label_i != cfg_i.match_label)) &&
                       !(cfg_i.channel_filter_on && (chan_i != cfg_i.match_channel));

endmodule

// File: sv/als_ctr_ram.sv
// ----------------------------------------------------------------------------
// ARINC 429 label statistics: counter memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module als_ctr_ram
  import als_pkg::*;
#(
  parameter int unsigned Depth = LabelEntriesDef,
  parameter int unsigned IdxW  = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  cnt_t            wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output cnt_t            rdata_o
);

  cnt_t mem_q [Depth];
  cnt_t rdata_q;

  // Synchronous write and read; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/arinc429_label_statistics.sv
// ----------------------------------------------------------------------------
// ARINC 429 label statistics monitor
// Counts words per label (total, channel 1, channel 2, parity errors) and
// overall, checks odd parity and reports filter matches, one result per word.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Moves
//  ---------+----------------------------+------------------------------------
//  in       | in_valid_i / in_ready_o    | one decoded word or a clear command
//  out      | out_valid_o / out_ready_i  | verdicts and updated counters
//  cfg      | cfg_we_i (no wait)         | filter register write
//
// On a word's accept edge the label's entry is read from the counter memory;
// the update edge (ST_UPD) writes the updated entry back and loads the output
// register. No word is accepted until the update is done, so reads always see
// the last write and no forwarding path is needed.
// Reset empties the table at once through per-entry valid bits; a clear
// command does the same in its update cycle. If the output register is
// still full, the update waits and the input stays stalled.
// ----------------------------------------------------------------------------
`include "arinc429_label_statistics_macros.svh"

module arinc429_label_statistics
  import als_pkg::*;
#(
  parameter int unsigned LABEL_ENTRIES = LabelEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [1:0]  chan_i,
  input  logic [7:0]  label_i,
  input  logic [1:0]  sdi_i,
  input  logic [18:0] payload_i,
  input  logic [1:0]  ssm_i,
  input  logic        parity_in_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        parity_good_o,
  output logic        filter_match_o,
  output logic [31:0] label_count_o,
  output logic [31:0] label_ch1_count_o,
  output logic [31:0] label_ch2_count_o,
  output logic [31:0] label_error_count_o,
  output logic [31:0] all_words_o,
  output logic [31:0] all_errors_o
);

  localparam int unsigned IdxW = $clog2(LABEL_ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  cfg_t cfg_q;
  chk_t chk;

  logic state_q, state_d;

  logic        cmd_q;
  logic [1:0]  chan_q;
  logic [7:0]  label_q;
  logic        in_rng_q;
  chk_t        chk_q;

  logic [LABEL_ENTRIES-1:0] valid_q;
  logic [CntW-1:0]          grand_words_q, grand_errors_q;
  logic [CntW-1:0]          grand_words_d, grand_errors_d;

  cnt_t rd_cnt, old_cnt, new_cnt;

  logic in_acc, out_free, upd_fire, wr_en;
  logic [IdxW-1:0] upd_idx;

  logic            out_valid_q;
  logic            out_good_q, out_match_q;
  cnt_t            out_cnt_q;
  logic [CntW-1:0] out_words_q, out_errs_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.label_filter_on   <= 1'b0;
      cfg_q.match_label       <= 8'd0;
      cfg_q.channel_filter_on <= 1'b0;
      cfg_q.match_channel     <= MATCH_CHANNEL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LABEL_FILTER_ON:   cfg_q.label_filter_on   <= cfg_wdata_i[0];
        REG_MATCH_LABEL:       cfg_q.match_label       <= cfg_wdata_i;
        REG_CHANNEL_FILTER_ON: cfg_q.channel_filter_on <= cfg_wdata_i[0];
        REG_MATCH_CHANNEL:     cfg_q.match_channel     <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // Parity and filter verdicts, taken at the accept edge.
  als_word_chk u_chk (
    .cfg_i       (cfg_q),
    .chan_i      (chan_i),
    .label_i     (label_i),
    .sdi_i       (sdi_i),
    .payload_i   (payload_i),
    .ssm_i       (ssm_i),
    .parity_in_i (parity_in_i),
    .chk_o       (chk)
  );

  // Handshake and sequencing.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign upd_fire   = (state_q == ST_UPD) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc)   state_d = ST_UPD;
      ST_UPD:  if (upd_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted word's fields for the update cycle.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= cmd_i;
      chan_q   <= chan_i;
      label_q  <= label_i;
      in_rng_q <= ({1'b0, label_i} < 9'(LABEL_ENTRIES));
      chk_q    <= chk;
    end
  end

  assign upd_idx = label_q[IdxW-1:0];

  // Counter memory, read on accept, written back in the update cycle.
  als_ctr_ram #(
    .Depth (LABEL_ENTRIES),
    .IdxW  (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (upd_idx),
    .wdata_i (new_cnt),
    .re_i    (in_acc),
    .raddr_i (label_i[IdxW-1:0]),
    .rdata_o (rd_cnt)
  );

  // Read-modify-write of the label entry.
  assign wr_en = upd_fire && (cmd_q == CMD_RECORD) && in_rng_q;

  always_comb begin
    old_cnt = '0;
    if (in_rng_q && valid_q[upd_idx]) begin
      old_cnt = rd_cnt;
    end
    new_cnt       = old_cnt;
    new_cnt.words = old_cnt.words + CntW'(1);
    if (chan_q == CHAN_ONE) begin
      new_cnt.ch1 = old_cnt.ch1 + CntW'(1);
    end
    if (chan_q == CHAN_TWO) begin
      new_cnt.ch2 = old_cnt.ch2 + CntW'(1);
    end
    if (!chk_q.good) begin
      new_cnt.errs = old_cnt.errs + CntW'(1);
    end
  end

  // Global totals.
  assign grand_words_d  = grand_words_q + CntW'(1);
  assign grand_errors_d = chk_q.good ? grand_errors_q : grand_errors_q + CntW'(1);

  // Valid bits and totals; a clear empties both.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      grand_words_q  <= '0;
      grand_errors_q <= '0;
    end else if (upd_fire) begin
      if (cmd_q == CMD_CLEAR) begin
        valid_q        <= '0;
        grand_words_q  <= '0;
        grand_errors_q <= '0;
      end else begin
        grand_words_q  <= grand_words_d;
        grand_errors_q <= grand_errors_d;
        if (in_rng_q) begin
          valid_q[upd_idx] <= 1'b1;
        end
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload; a clear reports all zero.
  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      if (cmd_q == CMD_CLEAR) begin
        out_good_q  <= 1'b0;
        out_match_q <= 1'b0;
        out_cnt_q   <= '0;
        out_words_q <= '0;
        out_errs_q  <= '0;
      end else begin
        out_good_q  <= chk_q.good;
        out_match_q <= chk_q.match;
        out_cnt_q   <= in_rng_q ? new_cnt : '0;
        out_words_q <= grand_words_d;
        out_errs_q  <= grand_errors_d;
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign parity_good_o       = out_good_q;
  assign filter_match_o      = out_match_q;
  assign label_count_o       = out_cnt_q.words;
  assign label_ch1_count_o   = out_cnt_q.ch1;
  assign label_ch2_count_o   = out_cnt_q.ch2;
  assign label_error_count_o = out_cnt_q.errs;
  assign all_words_o         = out_words_q;
  assign all_errors_o        = out_errs_q;

  // An accepted word always moves into its update cycle.
  `ALS_ASSERT_NEXT(a_acc_to_upd, clk_i, rst_ni, in_acc, state_q == ST_UPD)
  // A pending update never overwrites an untaken result.
  `ALS_ASSERT_SAME(a_no_overwrite, clk_i, rst_ni, upd_fire && out_valid_q, out_ready_i)
  // A clear leaves an empty table and zero totals.
  `ALS_ASSERT_NEXT(a_clear_empties, clk_i, rst_ni, upd_fire && (cmd_q == CMD_CLEAR),
                   (valid_q == '0) && (grand_words_q == '0) && (grand_errors_q == '0))

endmodule
